// ===== hdl/sps_pkg.sv =====
// Shared types, prefix table and lookup functions for the statement prefix matcher.
`timescale 1ns / 1ps

package sps_pkg;

	localparam int NumPfx = 37;
	localparam int PfxMax = 32;
	localparam int PosW = 6;

	localparam logic [1:0] GRP_NONE   = 2'd0;
	localparam logic [1:0] GRP_SHOW   = 2'd1;
	localparam logic [1:0] GRP_SELECT = 2'd2;
	localparam logic [1:0] GRP_SET    = 2'd3;

	localparam int ShowLast   = 20;
	localparam int SelectLast = 29;

	typedef logic [8*PfxMax-1:0] pfx_text_t;

	typedef struct packed {
		logic       emit;
		logic [7:0] ch;
		logic       last;
	} norm_beat_t;

	typedef struct packed {
		logic       suppress;
		logic [1:0] match_group;
	} match_res_t;

	localparam pfx_text_t PFX_TEXT [NumPfx] = '{
		"show databases", "show schemas", "show tables",
		"show full tables", "show table status", "show columns",
		"show fields", "show keys", "show indexes",
		"show index", "show variables", "show global variables",
		"show session variables", "show warnings", "show engines",
		"show character set", "show charset", "show collation",
		"show grants", "show create table", "show create database",
		"select database()", "select schema()", "select version()",
		{"select connec", "tion_id()"}, {"select current", "_user()"},
		"select user()", "select @@", "select @@session.",
		"select @@global.",
		"set names", {"set charac", "ter_set_results"}, "set autocommit",
		{"set sql_sel", "ect_limit"}, {"set net_wri", "te_timeout"},
		"set session transaction", "use "
	};

	function automatic logic [PosW-1:0] pfx_len(input int k);
		int n;
		n = 0;
		for (int b = 0; b < PfxMax; b++) begin
			if (PFX_TEXT[k][8*b +: 8] != 8'h00) begin
				n = n + 1;
			end
		end
		return PosW'(n);
	endfunction

	function automatic logic [7:0] pfx_char(input int k, input int j);
		int n;
		n = int'(pfx_len(k));
		if (j < n) begin
			return PFX_TEXT[k][8*(n-1-j) +: 8];
		end
		return 8'h00;
	endfunction

	function automatic logic [1:0] pfx_group(input int k);
		if (k <= ShowLast) begin
			return GRP_SHOW;
		end
		if (k <= SelectLast) begin
			return GRP_SELECT;
		end
		return GRP_SET;
	endfunction

endpackage

// ===== hdl/sps_fifo.sv =====
// Small register queue with push/full and pop/empty sides.
`timescale 1ns / 1ps

module sps_fifo #(
	parameter int Width = 8,
	parameter int Depth = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [Width-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [Width-1:0] dout,
	output logic             empty
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	logic [Width-1:0] mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign full    = (count_q == CntW'(Depth));
	assign empty   = (count_q == '0);
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/sps_front.sv =====
// Front end: accepts raw bytes, folds whitespace and case, and queues normalized beats.
`timescale 1ns / 1ps

module sps_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [7:0]          text_byte,
	input  logic                has_byte,
	input  logic                last,
	output logic                full,
	output logic                q_push,
	output sps_pkg::norm_beat_t q_beat,
	input  logic                q_full
);

	logic prev_space_q;
	logic ws;
	logic upper;
	logic accept;

	assign full   = q_full;
	assign accept = push && !q_full;
	assign q_push = accept;

	assign ws    = (text_byte == 8'h20) || (text_byte >= 8'h09 && text_byte <= 8'h0D);
	assign upper = (text_byte >= 8'h41) && (text_byte <= 8'h5A);

	always_comb begin
		q_beat.last = last;
		q_beat.emit = has_byte && (!ws || !prev_space_q);
		if (ws) begin
			q_beat.ch = 8'h20;
		end else if (upper) begin
			q_beat.ch = text_byte + 8'h20;
		end else begin
			q_beat.ch = text_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_space_q <= 1'b1;
		end else if (accept) begin
			if (last) begin
				prev_space_q <= 1'b1;
			end else if (has_byte) begin
				prev_space_q <= ws;
			end
		end
	end

endmodule

// ===== hdl/sps_back.sv =====
// Back end: tracks live prefixes per normalized character and emits the verdict at statement end.
`timescale 1ns / 1ps

module sps_back (
	input  logic                clk,
	input  logic                arst_n,
	input  sps_pkg::norm_beat_t q_beat,
	input  logic                q_empty,
	output logic                q_pop,
	output logic                r_push,
	output sps_pkg::match_res_t r_res,
	input  logic                r_full
);

	localparam int N = sps_pkg::NumPfx;
	localparam int W = sps_pkg::PosW;

	logic [N-1:0] alive_q;
	logic [W-1:0] pos_q;
	logic [W-1:0] reach_q;

	logic [N-1:0] mismatch;
	logic [N-1:0] alive_n;
	logic [W-1:0] pos_n;
	logic [W-1:0] reach_n;
	logic [N-1:0] hit;
	logic         hit_show;
	logic         hit_select;
	logic         hit_set;
	logic         advance;

	assign advance = !q_empty && (!q_beat.last || !r_full);
	assign q_pop   = advance;
	assign r_push  = advance && q_beat.last;

	always_comb begin
		for (int k = 0; k < N; k++) begin
			mismatch[k] = 1'b0;
			for (int j = 0; j < sps_pkg::PfxMax; j++) begin
				if (j < int'(sps_pkg::pfx_len(k))) begin
					mismatch[k] = mismatch[k] ||
						((pos_q == W'(j)) && (q_beat.ch != sps_pkg::pfx_char(k, j)));
				end
			end
		end
	end

	always_comb begin
		if (q_beat.emit) begin
			alive_n = alive_q & ~mismatch;
			pos_n   = (pos_q == {W{1'b1}}) ? pos_q : pos_q + 1'b1;
			reach_n = (q_beat.ch != 8'h20 && q_beat.ch != 8'h3B) ? pos_n : reach_q;
		end else begin
			alive_n = alive_q;
			pos_n   = pos_q;
			reach_n = reach_q;
		end
	end

	always_comb begin
		hit_show   = 1'b0;
		hit_select = 1'b0;
		hit_set    = 1'b0;
		for (int k = 0; k < N; k++) begin
			hit[k] = alive_n[k] && (sps_pkg::pfx_len(k) <= reach_n);
			if (sps_pkg::pfx_group(k) == sps_pkg::GRP_SHOW) begin
				hit_show = hit_show || hit[k];
			end else if (sps_pkg::pfx_group(k) == sps_pkg::GRP_SELECT) begin
				hit_select = hit_select || hit[k];
			end else begin
				hit_set = hit_set || hit[k];
			end
		end
		r_res.suppress = |hit;
		priority if (hit_show) begin
			r_res.match_group = sps_pkg::GRP_SHOW;
		end else if (hit_select) begin
			r_res.match_group = sps_pkg::GRP_SELECT;
		end else if (hit_set) begin
			r_res.match_group = sps_pkg::GRP_SET;
		end else begin
			r_res.match_group = sps_pkg::GRP_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= '1;
			pos_q   <= '0;
			reach_q <= '0;
		end else if (advance) begin
			if (q_beat.last) begin
				alive_q <= '1;
				pos_q   <= '0;
				reach_q <= '0;
			end else begin
				alive_q <= alive_n;
				pos_q   <= pos_n;
				reach_q <= reach_n;
			end
		end
	end

endmodule

// ===== hdl/sql_prefix_suppress_matcher.sv =====
// Top level of the statement prefix matcher: front end, beat queue, back end, result queue.
`timescale 1ns / 1ps

// Usage:
// Input side is a queue write port: drive text_byte, has_byte and last with push;
// a beat is taken at a rising edge with push high and full low. One beat per byte
// of the statement, last high on the final one; has_byte low carries no byte.
// Result side is a queue read port: while empty is low, suppress and match_group
// show the oldest verdict; pop high with empty low takes it. One verdict per
// statement, on its last beat.
// Throughput: one beat per cycle while the result queue has room, set by
// the combinational classify in the front end and the back end prefix update.
// Path: a taken last beat is registered in the beat queue; once it is at the
// head and the result queue has room, the back end pushes its verdict into the
// result queue, which registers it before it shows on the result ports to pop.
// Stall: when the result queue fills, the back end holds last beats, the beat
// queue fills behind it (MidDepth beats), and full rises toward the sender.
// Reset: arst_n low empties both queues and returns the matcher to the start of
// a statement; no clearing pass is needed.

module sql_prefix_suppress_matcher #(
	parameter int MidDepth = 4,
	parameter int OutDepth = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] text_byte,
	input  logic       has_byte,
	input  logic       last,
	output logic       empty,
	input  logic       pop,
	output logic       suppress,
	output logic [1:0] match_group
);

	localparam int BeatW = $bits(sps_pkg::norm_beat_t);
	localparam int ResW  = $bits(sps_pkg::match_res_t);

	sps_pkg::norm_beat_t fe_beat;
	sps_pkg::norm_beat_t be_beat;
	sps_pkg::match_res_t be_res;
	sps_pkg::match_res_t out_res;
	logic                fe_push;
	logic                mid_full;
	logic                mid_empty;
	logic                be_pop;
	logic                be_push;
	logic                res_full;

	sps_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.text_byte(text_byte),
		.has_byte (has_byte),
		.last     (last),
		.full     (full),
		.q_push   (fe_push),
		.q_beat   (fe_beat),
		.q_full   (mid_full)
	);

	sps_fifo #(
		.Width(BeatW),
		.Depth(MidDepth)
	) u_mid_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (fe_push),
		.din   (fe_beat),
		.full  (mid_full),
		.pop   (be_pop),
		.dout  (be_beat),
		.empty (mid_empty)
	);

	sps_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_beat (be_beat),
		.q_empty(mid_empty),
		.q_pop  (be_pop),
		.r_push (be_push),
		.r_res  (be_res),
		.r_full (res_full)
	);

	sps_fifo #(
		.Width(ResW),
		.Depth(OutDepth)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (be_push),
		.din   (be_res),
		.full  (res_full),
		.pop   (pop),
		.dout  (out_res),
		.empty (empty)
	);

	assign suppress    = out_res.suppress;
	assign match_group = out_res.match_group;

endmodule

// ===== verif/testbench.sv =====
// Testbench for the statement prefix matcher: directed and random statements checked against a predictor.
`timescale 1ns / 1ps

module testbench;

	localparam int Prefixes = 37;
	localparam int LastShow = 20;
	localparam int LastSelect = 29;
	localparam logic [5:0] NormCap = 6'd63;
	localparam int WatchLimit = 3000;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CASE_GAP = 8'h20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic [7:0] text_byte = 8'h00;
	logic has_byte = 1'b0;
	logic last = 1'b0;
	logic pop = 1'b0;
	logic full;
	logic empty;
	logic suppress;
	logic [1:0] match_group;

	string prefix_text [Prefixes] = '{
		"show databases", "show schemas", "show tables",
		"show full tables", "show table status", "show columns",
		"show fields", "show keys", "show indexes",
		"show index", "show variables", "show global variables",
		"show session variables", "show warnings", "show engines",
		"show character set", "show charset", "show collation",
		"show grants", "show create table", "show create database",
		"select database()", "select schema()", "select version()",
		{string'("select connec"), "tion_id()"}, {string'("select current"), "_user()"},
		"select user()", "select @@", "select @@session.",
		"select @@global.",
		"set names", {string'("set charac"), "ter_set_results"}, "set autocommit",
		{string'("set sql_sel"), "ect_limit"}, {string'("set net_wri"), "te_timeout"},
		"set session transaction", "use "
	};

	logic [Prefixes-1:0] live_prefixes;
	logic [5:0] norm_len;
	logic after_space;
	logic [5:0] sig_len;

	sps_pkg::match_res_t verdict_q [$];
	logic [7:0] stmt_q [$];

	int send_idle_pct = 7;
	int recv_idle_pct = 48;
	int beats_sent = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	sql_prefix_suppress_matcher uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.text_byte(text_byte),
		.has_byte(has_byte),
		.last(last),
		.empty(empty),
		.pop(pop),
		.suppress(suppress),
		.match_group(match_group)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic [1:0] group_of(input int k);
		if (k <= LastShow) begin
			return sps_pkg::GRP_SHOW;
		end
		if (k <= LastSelect) begin
			return sps_pkg::GRP_SELECT;
		end
		return sps_pkg::GRP_SET;
	endfunction

	function automatic void clear_statement_state();
		live_prefixes = '1;
		norm_len = '0;
		after_space = 1'b1;
		sig_len = '0;
	endfunction

	function automatic void feed_char(input logic [7:0] c);
		int k;
		string t;
		for (k = 0; k < Prefixes; k++) begin
			t = prefix_text[k];
			if (int'(norm_len) < t.len() && 8'(t[norm_len]) != c) begin
				live_prefixes[k] = 1'b0;
			end
		end
		if (norm_len != NormCap) begin
			norm_len = norm_len + 6'd1;
		end
		if (c != CH_SPACE && c != CH_SEMI) begin
			sig_len = norm_len;
		end
	endfunction

	function automatic void absorb_beat(input logic [7:0] b, input logic has, input logic fin);
		logic [7:0] c;
		sps_pkg::match_res_t v;
		int k;
		if (has) begin
			c = b;
			if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
				if (!after_space) begin
					feed_char(CH_SPACE);
					after_space = 1'b1;
				end
			end else begin
				if (c >= CH_UA && c <= CH_UZ) begin
					c = c + CASE_GAP;
				end
				feed_char(c);
				after_space = 1'b0;
			end
		end
		if (fin) begin
			v.suppress = 1'b0;
			v.match_group = sps_pkg::GRP_NONE;
			for (k = 0; k < Prefixes; k++) begin
				if (!v.suppress && live_prefixes[k] && prefix_text[k].len() <= int'(sig_len)) begin
					v.suppress = 1'b1;
					v.match_group = group_of(k);
				end
			end
			verdict_q.insert(verdict_q.size(), v);
			clear_statement_state();
		end
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
		mismatches++;
	endtask

	task automatic check_verdict();
		sps_pkg::match_res_t want;
		if (verdict_q.size() == 0) begin
			report_mismatch("verdict with none pending", int'(suppress), -1);
		end else begin
			want = verdict_q.pop_front();
			if (suppress !== want.suppress) begin
				report_mismatch("suppress", int'(suppress), int'(want.suppress));
			end
			if (match_group !== want.match_group) begin
				report_mismatch("match_group", int'(match_group), int'(want.match_group));
			end
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				check_verdict();
			end
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= WatchLimit) begin
				$display("%0t ns: no beat moved for %0d cycles", $time, WatchLimit);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	task automatic send_beat(input logic [7:0] b, input logic has, input logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		text_byte <= b;
		has_byte <= has;
		last <= fin;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
		absorb_beat(b, has, fin);
		beats_sent++;
	endtask

	task automatic send_stmt(input int gap_pct, input bit close_empty);
		int i;
		bit by_empty;
		by_empty = close_empty || (stmt_q.size() == 0);
		for (i = 0; i < stmt_q.size(); i++) begin
			if ($urandom_range(99) < gap_pct) begin
				send_beat(8'($urandom_range(255)), 1'b0, 1'b0);
			end
			send_beat(stmt_q[i], 1'b1, !by_empty && (i == stmt_q.size() - 1));
		end
		if (by_empty) begin
			send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
		end
	endtask

	function automatic void add_byte(input logic [7:0] b);
		stmt_q.insert(stmt_q.size(), b);
	endfunction

	function automatic void load_text(input string s);
		int i;
		stmt_q.delete();
		for (i = 0; i < s.len(); i++) begin
			add_byte(8'(s[i]));
		end
	endfunction

	function automatic logic [7:0] random_ws();
		int r;
		r = $urandom_range(5);
		if (r == 5) begin
			return CH_SPACE;
		end
		return CH_TAB + 8'(r);
	endfunction

	function automatic void make_random_statement();
		int kind;
		int k;
		int i;
		int n;
		int tail;
		int r;
		string t;
		logic [7:0] c;
		stmt_q.delete();
		kind = $urandom_range(99);
		if (kind < 70) begin
			k = $urandom_range(Prefixes - 1);
			t = prefix_text[k];
			n = t.len();
			if ($urandom_range(99) < 20) begin
				n = $urandom_range(n, 1);
			end
			repeat ($urandom_range(2)) add_byte(random_ws());
			for (i = 0; i < n; i++) begin
				c = 8'(t[i]);
				if (c == CH_SPACE) begin
					repeat ($urandom_range(3, 1)) add_byte(random_ws());
				end else begin
					if ($urandom_range(99) < 8) begin
						c = 8'($urandom_range(126, 33));
					end
					if (c >= CH_LA && c <= CH_LZ && $urandom_range(1) == 1) begin
						c = c - CASE_GAP;
					end
					add_byte(c);
				end
			end
			tail = ($urandom_range(99) < 4) ? $urandom_range(70, 50) : $urandom_range(10);
			repeat (tail) begin
				r = $urandom_range(9);
				if (r == 0) begin
					add_byte(random_ws());
				end else if (r == 1) begin
					add_byte(8'($urandom_range(255)));
				end else begin
					add_byte(8'($urandom_range(122, 97)));
				end
			end
			repeat ($urandom_range(3)) begin
				add_byte(($urandom_range(1) == 1) ? CH_SEMI : random_ws());
			end
		end else if (kind < 88) begin
			repeat ($urandom_range(20)) add_byte(8'($urandom_range(255)));
		end else begin
			repeat ($urandom_range(6)) begin
				add_byte(($urandom_range(1) == 1) ? CH_SEMI : random_ws());
			end
		end
	endfunction

	task automatic send_random_stmt();
		make_random_statement();
		send_stmt(($urandom_range(99) < 15) ? 20 : 0, $urandom_range(99) < 10);
	endtask

	task automatic test_directed();
		stmt_q.delete();
		send_stmt(0, 1'b1);
		load_text(" \t\n\013\014\015;; ; ");
		send_stmt(0, 1'b0);
		load_text("SHOW DATABASES");
		send_stmt(0, 1'b0);
		load_text("\t\tSeLeCt  \n@@version");
		send_stmt(0, 1'b0);
		load_text("select @@");
		send_stmt(0, 1'b0);
		load_text("use ;");
		send_stmt(0, 1'b0);
		load_text("use   ");
		send_stmt(0, 1'b0);
		load_text("Use\013\014db;");
		send_stmt(0, 1'b0);
		load_text("show index");
		send_stmt(0, 1'b0);
		load_text("show indexes");
		send_stmt(30, 1'b1);
		load_text("show");
		send_stmt(0, 1'b0);
		load_text("set autocommit=1;;  ");
		send_stmt(0, 1'b0);
		load_text("select version() ");
		repeat (60) add_byte(8'h78);
		send_stmt(0, 1'b0);
		stmt_q.delete();
		add_byte(8'h00);
		add_byte(8'hFF);
		add_byte(8'h80);
		add_byte(8'h7F);
		repeat (66) add_byte(8'hFF);
		send_stmt(0, 1'b0);
	endtask

	task automatic test_random_phase(input int sender_pct, input int receiver_pct, input int budget);
		int start;
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
		start = beats_sent;
		while (beats_sent - start < budget) begin
			send_random_stmt();
		end
	endtask

	task automatic test_drain_pause();
		repeat (3) send_random_stmt();
		push <= 1'b0;
		while (verdict_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (3) send_random_stmt();
	endtask

	task automatic finish_run();
		push <= 1'b0;
		while (verdict_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (6) @(posedge clk);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	endtask

	initial begin
		clear_statement_state();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_phase(7, 48, 100);
		test_drain_pause();
		test_random_phase(48, 7, 100);
		test_random_phase(0, 0, 100);
		finish_run();
	end

endmodule

// ===== files.f =====
hdl/sps_pkg.sv
hdl/sps_fifo.sv
hdl/sps_front.sv
hdl/sps_back.sv
hdl/sql_prefix_suppress_matcher.sv
verif/testbench.sv
